@@ rtl/rsh_pkg.sv @@
// Shared constants, types and coefficient tables for the real spherical harmonics core.
// Depends on nothing; every other file in rtl/ imports it.
package rsh_pkg;

  localparam int MAX_DEGREE_BOUND_DEF = 7;
  localparam int VALUE_FRAC_BITS_DEF  = 16;

  localparam int QF      = 20;  // fraction bits of internal values
  localparam int STORE_W = 24;
  localparam int MUL_W   = 28;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int MQ_W    = PROD_W - QF;
  localparam int OUT_W   = 20;

  localparam int SQ_IN_W  = 44;
  localparam int SQ_OUT_W = 22;
  localparam int DV_N_W   = 42;
  localparam int DV_D_W   = 22;

  localparam logic signed [STORE_W-1:0] K_INV_SQRT_2PI = 24'sd418321;
  localparam logic signed [STORE_W-1:0] K_INV_SQRT_2   = 24'sd741455;
  localparam logic signed [STORE_W-1:0] Q_ONE          = 24'sd1048576;
  localparam logic signed [PROD_W-1:0]  MQ_HALF        = 56'sd524288;

  typedef struct packed {
    logic busy;
    logic done;
  } rsh_unit_stat_t;

  typedef logic [63:0][STORE_W-1:0] rom64_t;
  typedef logic [7:0][STORE_W-1:0]  rom8_t;

  // floor sqrt(num/den) in Q.20 by bitwise search, zero where the ratio means nothing
  function automatic logic [STORE_W-1:0] coef_c(input longint num, input longint den);
    longint unsigned lim;
    longint unsigned r;
    longint unsigned cand;
    if (den <= 0 || num <= 0) begin
      return '0;
    end
    lim = longint'(num) << (2 * QF);
    r   = 0;
    for (int b = STORE_W - 1; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand * longint'(den) <= lim) begin
        r = cand;
      end
    end
    return STORE_W'(r);
  endfunction

  function automatic rom64_t build_rom_a();
    rom64_t t;
    for (int l = 0; l < 8; l++) begin
      for (int m = 0; m < 8; m++) begin
        t[l * 8 + m] = coef_c(4 * l * l - 1, l * l - m * m);
      end
    end
    return t;
  endfunction

  function automatic rom64_t build_rom_b();
    rom64_t t;
    for (int l = 0; l < 8; l++) begin
      for (int m = 0; m < 8; m++) begin
        t[l * 8 + m] = coef_c((l - 1) * (l - 1) - m * m, 4 * (l - 1) * (l - 1) - 1);
      end
    end
    return t;
  endfunction

  function automatic rom8_t build_rom_c1();
    rom8_t t;
    for (int l = 0; l < 8; l++) begin
      t[l] = coef_c(2 * l + 1, 1);
    end
    return t;
  endfunction

  function automatic rom8_t build_rom_c2();
    rom8_t t;
    for (int l = 0; l < 8; l++) begin
      t[l] = coef_c(2 * l + 1, 2 * l);
    end
    return t;
  endfunction

  localparam rom64_t ROM_A  = build_rom_a();
  localparam rom64_t ROM_B  = build_rom_b();
  localparam rom8_t  ROM_C1 = build_rom_c1();
  localparam rom8_t  ROM_C2 = build_rom_c2();

  // round half up from a raw product back to Q.20
  function automatic logic signed [MQ_W-1:0] mulq(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] w;
    w = p + MQ_HALF;
    return w[PROD_W-1:QF];
  endfunction

  function automatic logic signed [STORE_W-1:0] sat24(input logic signed [MQ_W-1:0] v);
    if (v > 36'sd8388607) begin
      return 24'sh7FFFFF;
    end
    if (v < -36'sd8388608) begin
      return 24'sh800000;
    end
    return v[STORE_W-1:0];
  endfunction

endpackage

@@ rtl/rsh_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on rsh_pkg for widths and the unit status struct.
module rsh_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rsh_pkg::SQ_IN_W-1:0]    rad_i,
  output rsh_pkg::rsh_unit_stat_t        stat_o,
  output logic [rsh_pkg::SQ_OUT_W-1:0]   root_o
);
  import rsh_pkg::*;

  localparam int REM_W = SQ_OUT_W + 4;
  localparam int CNT_W = $clog2(SQ_OUT_W);

  logic [SQ_IN_W-1:0]  rad_q;
  logic [REM_W-1:0]    rem_q;
  logic [SQ_OUT_W-1:0] root_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                ge;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_IN_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQ_OUT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQ_IN_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[SQ_OUT_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

@@ rtl/rsh_div.sv @@
// Iterative restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on rsh_pkg for widths and the unit status struct.
module rsh_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rsh_pkg::DV_N_W-1:0]   num_i,
  input  logic [rsh_pkg::DV_D_W-1:0]   den_i,
  output rsh_pkg::rsh_unit_stat_t      stat_o,
  output logic [rsh_pkg::DV_N_W-1:0]   quo_o
);
  import rsh_pkg::*;

  localparam int CNT_W = $clog2(DV_N_W);

  logic [DV_N_W-1:0] num_q;
  logic [DV_D_W:0]   rem_q;
  logic [DV_D_W-1:0] den_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DV_D_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q[DV_D_W-1:0], num_q[DV_N_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      num_q <= {num_q[DV_N_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = num_q;

endmodule

@@ rtl/real_spherical_harmonics_core.sv @@
// Top level of the real spherical harmonics core: sequencer, shared multiplier, stores.
// Depends on rsh_pkg, rsh_sqrt and rsh_div.
//
// One unit direction (Q2.14) goes in with start while busy is low; the block then
// emits Y_l^m for l = 0..L and m = -l..l, L = min(max_degree, MAX_DEGREE_BOUND), one
// word per result_valid_o strobe, last_value_o set on the final word. Results cannot
// be held off: each word is on the ports for exactly one cycle, so the receiver must
// take it. The division part drops out on the z axis. The root and quotient units work
// one bit per cycle, and the single multiplier is used by every recurrence step and
// every result word in turn.
module real_spherical_harmonics_core #(
  parameter int MAX_DEGREE_BOUND = rsh_pkg::MAX_DEGREE_BOUND_DEF,
  parameter int VALUE_FRAC_BITS  = rsh_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [2:0]         degree_l_o,
  output logic signed [3:0]  order_m_o,
  output logic signed [19:0] harmonic_value_o,
  output logic               last_value_o
);
  import rsh_pkg::*;

  localparam int LEG_DEPTH = (MAX_DEGREE_BOUND + 1) * (MAX_DEGREE_BOUND + 2) / 2;
  localparam int ANG_DEPTH = 2 * (MAX_DEGREE_BOUND + 1);
  localparam int LA_W      = $clog2(LEG_DEPTH);
  localparam int AA_W      = $clog2(ANG_DEPTH);
  localparam int ESH       = 2 * QF - VALUE_FRAC_BITS;
  localparam logic [2:0] MDB3 = 3'(MAX_DEGREE_BOUND);
  localparam logic signed [PROD_W-1:0] E_HALF    = PROD_W'(64'd1 << (ESH - 1));
  localparam logic signed [PROD_W-1:0] OUT_MAX_W = 56'sd524287;
  localparam logic signed [PROD_W-1:0] OUT_MIN_W = -56'sd524288;
  localparam logic [1:0] CFG_MAX_DEGREE = 2'd0;
  localparam logic [1:0] CFG_XY_TOL     = 2'd1;

  typedef enum logic [5:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_SQRT_S, S_SQRT_SW, S_SQRT_R, S_SQRT_RW, S_PHI,
    S_DIV_X, S_DIV_XW, S_DIV_Y, S_DIV_YW, S_AINIT, S_AR_RD, S_AR_MUL, S_AR_WR,
    S_LINIT, S_LA_RD, S_LA_M1, S_LA_M2, S_LA_M3, S_LA_M4, S_LA_WR,
    S_DG1, S_DG2, S_DG3, S_DG4, S_DG5, S_DG6, S_DG7, S_E_RD, S_E_MUL, S_E_OUT
  } state_e;

  state_e state_q;

  logic [2:0]  max_deg_q;
  logic [14:0] tol_q;

  logic signed [15:0]        x_q, y_q, z_q;
  logic [31:0]               acc_q;
  logic signed [STORE_W-1:0] sin_q, cphi_q, sphi_q, dacc_q;
  logic [SQ_OUT_W-1:0]       r_q;
  logic [2:0]                lmax_q, l_q, m_q;
  logic                      k_q;
  logic [1:0]                cnt_q;
  logic signed [3:0]         mm_q;
  logic signed [MUL_W-1:0]   t_q, inner_q;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [MQ_W-1:0]    mq;

  logic signed [STORE_W-1:0] leg_mem [LEG_DEPTH];
  logic signed [STORE_W-1:0] ang_mem [ANG_DEPTH];
  logic signed [STORE_W-1:0] leg_rd_q, ang_rd_q;
  logic [LA_W-1:0]           leg_ra, leg_wa;
  logic [AA_W-1:0]           ang_ra, ang_wa;
  logic                      leg_we, ang_we;
  logic signed [STORE_W-1:0] leg_wd, ang_wd;

  logic                      sq_start, dv_start;
  logic [SQ_IN_W-1:0]        sq_rad;
  logic [DV_N_W-1:0]         dv_num;
  rsh_unit_stat_t            sq_stat, dv_stat;
  logic [SQ_OUT_W-1:0]       sq_root;
  logic [DV_N_W-1:0]         dv_quo;

  logic signed [21:0]        z20;
  logic [15:0]               xa, ya;
  logic [2:0]                am;
  logic signed [STORE_W-1:0] dneg;
  logic signed [PROD_W-1:0]  er, ev;
  logic signed [19:0]        hv;
  logic signed [STORE_W-1:0] q24;

  function automatic logic [LA_W-1:0] lidx(input logic [2:0] l, input logic [2:0] m);
    logic [5:0] l6;
    logic [5:0] tri6;
    l6   = {3'b000, l};
    tri6 = 6'((l6 * (l6 + 6'd1)) >> 1);
    return LA_W'(tri6 + {3'b000, m});
  endfunction

  function automatic logic [AA_W-1:0] aidx(input logic [2:0] m, input logic k);
    return AA_W'({m, k});
  endfunction

  assign z20  = {z_q, 6'b000000};
  assign xa   = x_q[15] ? 16'(-x_q) : x_q;
  assign ya   = y_q[15] ? 16'(-y_q) : y_q;
  assign am   = mm_q[3] ? 3'(-mm_q) : mm_q[2:0];
  assign mq   = mulq(prod_q);
  assign dneg = sat24(-mq);
  assign q24  = dv_quo[STORE_W-1:0];
  assign er   = prod_q + E_HALF;
  assign ev   = er >>> ESH;
  assign hv   = (ev > OUT_MAX_W) ? 20'sh7FFFF : ((ev < OUT_MIN_W) ? 20'sh80000 : ev[19:0]);

  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  rsh_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .stat_o  (sq_stat),
    .root_o  (sq_root)
  );

  rsh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (r_q),
    .stat_o  (dv_stat),
    .quo_o   (dv_quo)
  );

  // operand selection for the shared multiplier, stores and iterative units
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    leg_ra   = lidx(l_q, am);
    ang_ra   = aidx(am, mm_q[3]);
    leg_we   = 1'b0;
    leg_wa   = lidx(l_q, m_q);
    leg_wd   = sat24(mq);
    ang_we   = 1'b0;
    ang_wa   = aidx(m_q, k_q);
    ang_wd   = sat24(mq - MQ_W'(ang_rd_q));
    sq_start = 1'b0;
    sq_rad   = {acc_q, 12'h000};
    dv_start = 1'b0;
    dv_num   = {xa, 26'h0};
    case (state_q)
      S_SQX: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(x_q);
      end
      S_SQY: begin
        mul_a = MUL_W'(y_q);
        mul_b = MUL_W'(y_q);
      end
      S_SQZ: begin
        mul_a = MUL_W'(z_q);
        mul_b = MUL_W'(z_q);
      end
      S_SQRT_S: begin
        sq_start = 1'b1;
        // clamp 1 - z^2 at zero for oversized z
        if (prod_q > 56'sd268435456) begin
          sq_rad = '0;
        end else begin
          sq_rad = SQ_IN_W'({29'(29'h10000000 - prod_q[28:0]), 12'h000});
        end
      end
      S_SQRT_R: sq_start = 1'b1;
      S_DIV_X: dv_start = 1'b1;
      S_DIV_Y: begin
        dv_start = 1'b1;
        dv_num   = {ya, 26'h0};
      end
      S_AINIT: begin
        ang_we = 1'b1;
        ang_wa = AA_W'(cnt_q);
        case (cnt_q)
          2'd0:    ang_wd = Q_ONE;
          2'd1:    ang_wd = '0;
          2'd2:    ang_wd = cphi_q;
          default: ang_wd = sphi_q;
        endcase
      end
      S_AR_RD: ang_ra = aidx(m_q - 3'd1, k_q);
      S_AR_MUL: begin
        mul_a  = MUL_W'($signed({cphi_q, 1'b0}));
        mul_b  = MUL_W'(ang_rd_q);
        ang_ra = aidx(m_q - 3'd2, k_q);
      end
      S_AR_WR: ang_we = 1'b1;
      S_LINIT: begin
        leg_we = 1'b1;
        leg_wa = '0;
        leg_wd = K_INV_SQRT_2PI;
      end
      S_LA_RD: leg_ra = lidx(l_q - 3'd1, m_q);
      S_LA_M1: begin
        mul_a  = MUL_W'(z20);
        mul_b  = MUL_W'(leg_rd_q);
        leg_ra = lidx(l_q - 3'd2, m_q);
      end
      S_LA_M2: begin
        mul_a = MUL_W'(ROM_B[{l_q, m_q}]);
        mul_b = MUL_W'(leg_rd_q);
      end
      S_LA_M4: begin
        mul_a = MUL_W'(ROM_A[{l_q, m_q}]);
        mul_b = inner_q;
      end
      S_LA_WR: leg_we = 1'b1;
      S_DG1: begin
        mul_a = MUL_W'(z20);
        mul_b = MUL_W'(ROM_C1[l_q]);
      end
      S_DG3: begin
        mul_a = t_q;
        mul_b = MUL_W'(dacc_q);
      end
      S_DG4: begin
        leg_we = 1'b1;
        leg_wa = lidx(l_q, l_q - 3'd1);
        mul_a  = MUL_W'(dacc_q);
        mul_b  = MUL_W'(sin_q);
      end
      S_DG6: begin
        mul_a = t_q;
        mul_b = MUL_W'(ROM_C2[l_q]);
      end
      S_DG7: begin
        leg_we = 1'b1;
        leg_wa = lidx(l_q, l_q);
        leg_wd = dneg;
      end
      S_E_MUL: begin
        mul_a = MUL_W'(leg_rd_q);
        mul_b = (mm_q == 4'sd0) ? MUL_W'(K_INV_SQRT_2) : MUL_W'(ang_rd_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= mul_a * mul_b;
    leg_rd_q <= leg_mem[leg_ra];
    ang_rd_q <= ang_mem[ang_ra];
    if (leg_we) begin
      leg_mem[leg_wa] <= leg_wd;
    end
    if (ang_we) begin
      ang_mem[ang_wa] <= ang_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      max_deg_q        <= 3'd7;
      tol_q            <= 15'd1;
      dacc_q           <= '0;
      result_valid_o   <= 1'b0;
      x_q              <= '0;
      y_q              <= '0;
      z_q              <= '0;
      acc_q            <= '0;
      sin_q            <= '0;
      cphi_q           <= '0;
      sphi_q           <= '0;
      r_q              <= '0;
      lmax_q           <= '0;
      l_q              <= '0;
      m_q              <= '0;
      k_q              <= 1'b0;
      cnt_q            <= '0;
      mm_q             <= '0;
      t_q              <= '0;
      inner_q          <= '0;
      degree_l_o       <= '0;
      order_m_o        <= '0;
      harmonic_value_o <= '0;
      last_value_o     <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MAX_DEGREE) begin
          max_deg_q <= cfg_data_i[2:0];
        end else if (cfg_index_i == CFG_XY_TOL) begin
          tol_q <= cfg_data_i;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            x_q     <= dir_x_i;
            y_q     <= dir_y_i;
            z_q     <= dir_z_i;
            lmax_q  <= (max_deg_q > MDB3) ? MDB3 : max_deg_q;
            state_q <= S_SQX;
          end
        end
        S_SQX: state_q <= S_SQY;
        S_SQY: begin
          acc_q   <= prod_q[31:0];
          state_q <= S_SQZ;
        end
        S_SQZ: begin
          acc_q   <= acc_q + prod_q[31:0];
          state_q <= S_SQRT_S;
        end
        S_SQRT_S: state_q <= S_SQRT_SW;
        S_SQRT_SW: begin
          if (sq_stat.done) begin
            sin_q   <= STORE_W'(sq_root);
            state_q <= S_SQRT_R;
          end
        end
        S_SQRT_R: state_q <= S_SQRT_RW;
        S_SQRT_RW: begin
          if (sq_stat.done) begin
            r_q     <= sq_root;
            state_q <= S_PHI;
          end
        end
        S_PHI: begin
          cnt_q <= '0;
          if (r_q != '0 && r_q >= {1'b0, tol_q, 6'b000000}) begin
            state_q <= S_DIV_X;
          end else begin
            cphi_q  <= Q_ONE;
            sphi_q  <= '0;
            state_q <= S_AINIT;
          end
        end
        S_DIV_X: state_q <= S_DIV_XW;
        S_DIV_XW: begin
          if (dv_stat.done) begin
            cphi_q  <= x_q[15] ? -q24 : q24;
            state_q <= S_DIV_Y;
          end
        end
        S_DIV_Y: state_q <= S_DIV_YW;
        S_DIV_YW: begin
          if (dv_stat.done) begin
            sphi_q  <= y_q[15] ? -q24 : q24;
            state_q <= S_AINIT;
          end
        end
        S_AINIT: begin
          cnt_q <= cnt_q + 2'd1;
          m_q   <= 3'd2;
          k_q   <= 1'b0;
          if ((cnt_q == 2'd1 && lmax_q == 3'd0) || (cnt_q == 2'd3 && lmax_q < 3'd2)) begin
            state_q <= S_LINIT;
          end else if (cnt_q == 2'd3) begin
            state_q <= S_AR_RD;
          end
        end
        S_AR_RD: state_q <= S_AR_MUL;
        S_AR_MUL: state_q <= S_AR_WR;
        S_AR_WR: begin
          k_q     <= ~k_q;
          state_q <= S_AR_RD;
          if (k_q) begin
            if (m_q == lmax_q) begin
              state_q <= S_LINIT;
            end else begin
              m_q <= m_q + 3'd1;
            end
          end
        end
        S_LINIT: begin
          dacc_q <= K_INV_SQRT_2PI;
          l_q    <= (lmax_q == 3'd0) ? 3'd0 : 3'd1;
          m_q    <= '0;
          mm_q   <= '0;
          state_q <= (lmax_q == 3'd0) ? S_E_RD : S_DG1;
        end
        S_LA_RD: state_q <= S_LA_M1;
        S_LA_M1: state_q <= S_LA_M2;
        S_LA_M2: begin
          t_q     <= mq[MUL_W-1:0];
          state_q <= S_LA_M3;
        end
        S_LA_M3: begin
          inner_q <= t_q - mq[MUL_W-1:0];
          state_q <= S_LA_M4;
        end
        S_LA_M4: state_q <= S_LA_WR;
        S_LA_WR: begin
          if (m_q == l_q - 3'd2) begin
            state_q <= S_DG1;
          end else begin
            m_q     <= m_q + 3'd1;
            state_q <= S_LA_RD;
          end
        end
        S_DG1: state_q <= S_DG2;
        S_DG2: begin
          t_q     <= mq[MUL_W-1:0];
          state_q <= S_DG3;
        end
        S_DG3: state_q <= S_DG4;
        S_DG4: state_q <= S_DG5;
        S_DG5: begin
          t_q     <= mq[MUL_W-1:0];
          state_q <= S_DG6;
        end
        S_DG6: state_q <= S_DG7;
        S_DG7: begin
          dacc_q <= dneg;
          m_q    <= '0;
          if (l_q == lmax_q) begin
            l_q     <= '0;
            mm_q    <= '0;
            state_q <= S_E_RD;
          end else begin
            l_q     <= l_q + 3'd1;
            state_q <= S_LA_RD;
          end
        end
        S_E_RD: state_q <= S_E_MUL;
        S_E_MUL: state_q <= S_E_OUT;
        S_E_OUT: begin
          result_valid_o   <= 1'b1;
          degree_l_o       <= l_q;
          order_m_o        <= mm_q;
          harmonic_value_o <= hv;
          last_value_o     <= (l_q == lmax_q) && (mm_q == $signed({1'b0, l_q}));
          state_q          <= S_E_RD;
          if (mm_q == $signed({1'b0, l_q})) begin
            if (l_q == lmax_q) begin
              state_q <= S_IDLE;
            end else begin
              l_q  <= l_q + 3'd1;
              mm_q <= -$signed({1'b0, l_q + 3'd1});
            end
          end else begin
            mm_q <= mm_q + 4'sd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/real_spherical_harmonics_core_tb.sv @@
// Self-checking testbench for real_spherical_harmonics_core: directed and random directions.
// Depends on rsh_pkg and the core; a scoreboard class predicts every harmonic word.
module real_spherical_harmonics_core_tb;
  import rsh_pkg::*;

  localparam logic [1:0] REG_MAX_DEGREE = 2'd0;
  localparam logic [1:0] REG_XY_TOL     = 2'd1;
  localparam logic [1:0] REG_SPARE      = 2'd2;
  localparam int         STALL_LIMIT    = 20000;
  localparam int         OUT_SHIFT      = 2 * QF - VALUE_FRAC_BITS_DEF;

  typedef struct {
    logic [2:0]         l;
    logic signed [3:0]  m;
    logic signed [19:0] value;
    logic               last;
  } harmonic_word_t;

  class harmonic_board;
    harmonic_word_t expected_words[$];
    longint         legendre[36];
    longint         angle_mult[16];
    longint         diag;
    int unsigned    degree_cfg;
    int unsigned    tol_cfg;
    int             errors;

    function new();
      degree_cfg = 7;
      tol_cfg    = 1;
      diag       = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] data);
      if (idx == REG_MAX_DEGREE) begin
        degree_cfg = data[2:0];
      end else if (idx == REG_XY_TOL) begin
        tol_cfg = data;
      end
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if (cand * cand <= v) r = cand;
      end
      return r;
    endfunction

    function longint coef(longint unsigned num, longint unsigned den);
      return longint'(root((num << (2 * QF)) / den));
    endfunction

    function longint mq(longint a, longint b);
      return (a * b + (64'sd1 <<< (QF - 1))) >>> QF;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function int li(int l, int m);
      return l * (l + 1) / 2 + m;
    endfunction

    // predict every word of one direction
    function void note_direction(logic signed [15:0] xi, logic signed [15:0] yi,
                                 logic signed [15:0] zi);
      longint x, y, z, z20, s2, sin_t, r20, cphi, sphi, p, f, v, a, b, inner;
      int lmax;
      harmonic_word_t w;
      x = xi; y = yi; z = zi;
      z20 = z * 64;
      s2 = (64'sd1 <<< 28) - z * z;
      if (s2 < 0) s2 = 0;
      sin_t = longint'(root(longint'(s2) << 12));
      r20 = longint'(root(longint'(x * x + y * y) << 12));
      cphi = 64'sd1 <<< QF;
      sphi = 0;
      if (r20 > 0 && r20 >= longint'(tol_cfg) * 64) begin
        cphi = (x * (64'sd1 <<< 26)) / r20;
        sphi = (y * (64'sd1 <<< 26)) / r20;
      end
      lmax = degree_cfg > 7 ? 7 : degree_cfg;
      angle_mult[0] = 64'sd1 <<< QF;
      angle_mult[1] = 0;
      if (lmax >= 1) begin
        angle_mult[2] = sat(cphi, -8388608, 8388607);
        angle_mult[3] = sat(sphi, -8388608, 8388607);
      end
      for (int m = 2; m <= lmax; m++) begin
        for (int k = 0; k < 2; k++) begin
          angle_mult[2 * m + k] = sat(mq(2 * cphi, angle_mult[2 * (m - 1) + k])
                                      - angle_mult[2 * (m - 2) + k], -8388608, 8388607);
        end
      end
      legendre[0] = 418321;
      diag = 418321;
      for (int l = 1; l <= lmax; l++) begin
        for (int m = 0; m + 2 <= l; m++) begin
          a = coef(4 * l * l - 1, l * l - m * m);
          b = coef((l - 1) * (l - 1) - m * m, 4 * (l - 1) * (l - 1) - 1);
          inner = mq(z20, legendre[li(l - 1, m)]) - mq(b, legendre[li(l - 2, m)]);
          legendre[li(l, m)] = sat(mq(a, inner), -8388608, 8388607);
        end
        legendre[li(l, l - 1)] = sat(mq(mq(z20, coef(2 * l + 1, 1)), diag),
                                     -8388608, 8388607);
        diag = sat(-mq(mq(diag, sin_t), coef(2 * l + 1, 2 * l)), -8388608, 8388607);
        legendre[li(l, l)] = diag;
      end
      for (int l = 0; l <= lmax; l++) begin
        for (int m = -l; m <= l; m++) begin
          p = legendre[li(l, m < 0 ? -m : m)];
          if (m < 0) f = angle_mult[2 * (-m) + 1];
          else if (m == 0) f = 741455;
          else f = angle_mult[2 * m];
          v = sat((p * f + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT, -524288, 524287);
          w.l = l[2:0];
          w.m = m[3:0];
          w.value = v[19:0];
          w.last = (l == lmax && m == l);
          expected_words.push_back(w);
        end
      end
    endfunction

    function void check_word(logic [2:0] l, logic signed [3:0] m,
                             logic signed [19:0] value, logic last);
      harmonic_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected word l=%0d m=%0d value=%0d", l, m, value);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (l !== w.l) begin
        $error("degree_l: expected %0d, got %0d", w.l, l); errors++;
      end
      if (m !== w.m) begin
        $error("order_m: expected %0d, got %0d", w.m, m); errors++;
      end
      if (value !== w.value) begin
        $error("harmonic_value: expected %0d, got %0d", w.value, value); errors++;
      end
      if (last !== w.last) begin
        $error("last_value: expected %0d, got %0d", w.last, last); errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] dir_x_i = '0;
  logic signed [15:0] dir_y_i = '0;
  logic signed [15:0] dir_z_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [14:0]        cfg_data_i = '0;
  logic               result_valid_o;
  logic [2:0]         degree_l_o;
  logic signed [3:0]  order_m_o;
  logic signed [19:0] harmonic_value_o;
  logic               last_value_o;

  harmonic_board board = new();
  int  stall_cycles = 0;
  bit  idle_on = 1'b1;

  real_spherical_harmonics_core uut (
    .clk_i, .rst_ni, .start, .busy, .dir_x_i, .dir_y_i, .dir_z_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .degree_l_o, .order_m_o, .harmonic_value_o, .last_value_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sample the pre-edge values of every handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_direction(dir_x_i, dir_y_i, dir_z_i);
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (result_valid_o) begin
        board.check_word(degree_l_o, order_m_o, harmonic_value_o, last_value_o);
      end
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // start stays high into the next direction unless an idle gap follows
  task automatic send_dir(logic signed [15:0] x, logic signed [15:0] y,
                          logic signed [15:0] z);
    start   <= 1'b1;
    dir_x_i <= x;
    dir_y_i <= y;
    dir_z_i <= z;
    do @(posedge clk_i); while (busy);
    if (idle_on && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  // hold off until the block is idle and every word has been checked
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || board.expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [14:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly near-unit directions, some raw noise and some almost on the z axis
  task automatic send_random();
    real th, ph;
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      th = $urandom_range(0, 100000) / 100000.0 * 3.14159265;
      ph = $urandom_range(0, 100000) / 100000.0 * 6.28318531;
      send_dir(16'($rtoi(16384.0 * $sin(th) * $cos(ph))),
               16'($rtoi(16384.0 * $sin(th) * $sin(ph))),
               16'($rtoi(16384.0 * $cos(th))));
    end else if (pick < 82) begin
      send_dir(16'($signed($urandom_range(0, 8)) - 4), 16'($signed($urandom_range(0, 8)) - 4),
               $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384);
    end else begin
      send_dir(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: axes, extremes, oversized and degenerate vectors
    send_dir(16'sd16384, 16'sd0, 16'sd0);
    send_dir(-16'sd16384, 16'sd0, 16'sd0);
    send_dir(16'sd0, 16'sd16384, 16'sd0);
    send_dir(16'sd0, -16'sd16384, 16'sd0);
    send_dir(16'sd0, 16'sd0, 16'sd16384);
    send_dir(16'sd0, 16'sd0, -16'sd16384);
    send_dir(16'sd0, 16'sd0, 16'sd0);
    send_dir(16'sd16384, 16'sd16384, 16'sd16384);
    send_dir(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_dir(-16'sh8000, -16'sh8000, -16'sh8000);
    send_dir(16'sh7FFF, -16'sh8000, 16'sd0);
    send_dir(16'sd1, 16'sd0, 16'sd16383);
    send_dir(16'sd11585, 16'sd11585, 16'sd0);
    send_dir(-16'sd9459, 16'sd9459, 16'sd9459);
    drain();
    write_cfg(REG_XY_TOL, 15'd16384);
    write_cfg(REG_MAX_DEGREE, 15'd0);
    write_cfg(REG_SPARE, 15'h7FFF);
    send_dir(16'sd8000, -16'sd8000, 16'sd8000);
    send_dir(16'sd16384, 16'sd0, 16'sd0);
    send_dir(-16'sd100, 16'sd200, 16'sd16300);
    drain();
    write_cfg(REG_XY_TOL, 15'h7FFF);
    write_cfg(REG_MAX_DEGREE, 15'd7);
    send_dir(16'sd16384, 16'sd0, 16'sd0);
    send_dir(-16'sh8000, 16'sh7FFF, 16'sd0);
    drain();

    // random phases over several settings, one with no idling
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_cfg(REG_MAX_DEGREE, 15'd7); write_cfg(REG_XY_TOL, 15'd0); end
        1: begin write_cfg(REG_MAX_DEGREE, 15'd1); write_cfg(REG_XY_TOL, 15'd1); end
        2: begin write_cfg(REG_MAX_DEGREE, 15'd7); write_cfg(REG_XY_TOL, 15'd64); end
        3: begin write_cfg(REG_MAX_DEGREE, 15'd0); write_cfg(REG_XY_TOL, 15'h7FFF); end
        default: begin
          write_cfg(REG_MAX_DEGREE, 15'($urandom_range(2, 6)));
          write_cfg(REG_XY_TOL, 15'($urandom_range(0, 2000)));
        end
      endcase
      idle_on = (phase != 2);
      for (int i = 0; i < 40; i++) send_random();
      drain();
    end

    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
